// ===== rtl/ddsr_pkg.sv =====
// Shared types and constants for the differential drive speed ramp.
package ddsr_pkg;

  localparam int unsigned SPEED_W  = 10;
  localparam int unsigned CORR_W   = 11;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [SPEED_W-1:0] speed_t;
  typedef logic signed [CORR_W-1:0] corr_t;

  localparam speed_t SPEED_MAX      = speed_t'(1023);
  localparam speed_t RAMP_DOWN_STEP = speed_t'(32);
  localparam speed_t RAMP_UP_STEP   = speed_t'(16);
  localparam speed_t SLOW_RESET     = speed_t'(256);
  localparam speed_t NORMAL_RESET   = speed_t'(512);

  typedef enum logic [MODE_W-1:0] {
    MODE_RAMP_DOWN = 3'd0,
    MODE_SLOW      = 3'd1,
    MODE_RAMP_UP   = 3'd2,
    MODE_STOP      = 3'd3
  } drive_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOW_SPEED   = 2'd0,
    CFG_NORMAL_SPEED = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    speed_t slow_speed;
    speed_t normal_speed;
  } cfg_t;

  // Handshake between the speed stage and the output stage
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_hs_t;

endpackage

// ===== rtl/ddsr_cfg.sv =====
// Configuration register file: slow and normal speed.
module ddsr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ddsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ddsr_pkg::SPEED_W-1:0]   cfg_wdata,
  output ddsr_pkg::cfg_t                cfg
);
  import ddsr_pkg::*;

  speed_t slow_speed_r;
  speed_t normal_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_speed_r   <= SLOW_RESET;
      normal_speed_r <= NORMAL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SLOW_SPEED:   slow_speed_r   <= cfg_wdata;
        CFG_NORMAL_SPEED: normal_speed_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.slow_speed   = slow_speed_r;
  assign cfg.normal_speed = normal_speed_r;

endmodule

// ===== rtl/ddsr_speed.sv =====
// Base speed state and the per-mode ramp update, plus the first stage register.
module ddsr_speed (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ddsr_pkg::cfg_t              cfg,
  input  logic                        accept,
  input  logic                        advance,
  input  logic [ddsr_pkg::MODE_W-1:0] drive_mode,
  input  ddsr_pkg::corr_t             steer_correction,
  output logic                        stage_valid,
  output ddsr_pkg::speed_t            speed,
  output ddsr_pkg::corr_t             corr
);
  import ddsr_pkg::*;

  speed_t           base_speed_r;
  speed_t           base_speed_nxt;
  corr_t            corr_r;
  logic             valid_r;
  logic [SPEED_W:0] up_sum;

  assign up_sum = {1'b0, base_speed_r} + {1'b0, RAMP_UP_STEP};

  always_comb begin
    base_speed_nxt = base_speed_r;
    case (drive_mode)
      MODE_SLOW: begin
        base_speed_nxt = cfg.slow_speed;
      end
      MODE_RAMP_UP: begin
        if (base_speed_r < cfg.normal_speed) begin
          base_speed_nxt = up_sum[SPEED_W] ? SPEED_MAX : up_sum[SPEED_W-1:0];
        end
      end
      MODE_STOP: begin
        base_speed_nxt = '0;
      end
      default: begin
        // ramp down, floored at zero
        base_speed_nxt = (base_speed_r >= RAMP_DOWN_STEP) ?
                         base_speed_r - RAMP_DOWN_STEP : '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_speed_r <= '0;
      valid_r      <= 1'b0;
    end else begin
      if (accept) begin
        base_speed_r <= base_speed_nxt;
      end
      if (advance) begin
        valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      corr_r <= steer_correction;
    end
  end

  assign stage_valid = valid_r;
  assign speed       = base_speed_r;
  assign corr        = corr_r;

endmodule

// ===== rtl/ddsr_mix.sv =====
// Correction clamp, left/right mixing with saturation, and the result register.
module ddsr_mix (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ddsr_pkg::speed_t     speed,
  input  ddsr_pkg::corr_t      corr,
  input  logic                 stage_valid,
  output ddsr_pkg::stage_hs_t  hs,
  input  logic                 out_stall,
  output logic                 out_valid,
  output ddsr_pkg::speed_t     out_left_duty,
  output ddsr_pkg::speed_t     out_right_duty
);
  import ddsr_pkg::*;

  localparam int unsigned SUM_W = SPEED_W + 2;

  logic signed [SUM_W-1:0] spd_s;
  logic signed [SUM_W-1:0] corr_s;
  logic signed [SUM_W-1:0] corr_cl;
  logic signed [SUM_W-1:0] left_s;
  logic signed [SUM_W-1:0] right_s;
  speed_t                  left_sat;
  speed_t                  right_sat;
  logic                    out_adv;
  logic                    out_valid_r;
  speed_t                  left_r;
  speed_t                  right_r;

  assign spd_s  = $signed({2'b00, speed});
  assign corr_s = SUM_W'(corr);

  always_comb begin
    corr_cl = corr_s;
    if (corr_s < -spd_s) begin
      corr_cl = -spd_s;
    end else if (corr_s > spd_s) begin
      corr_cl = spd_s;
    end
  end

  // after the clamp both sums lie in 0 .. 2*speed, so only the top needs saturating
  assign left_s    = spd_s + corr_cl;
  assign right_s   = spd_s - corr_cl;
  assign left_sat  = left_s[SPEED_W]  ? SPEED_MAX : left_s[SPEED_W-1:0];
  assign right_sat = right_s[SPEED_W] ? SPEED_MAX : right_s[SPEED_W-1:0];

  assign out_adv    = !out_valid_r || !out_stall;
  assign hs.valid   = stage_valid;
  assign hs.advance = !stage_valid || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && stage_valid) begin
      left_r  <= left_sat;
      right_r <= right_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_left_duty  = left_r;
  assign out_right_duty = right_r;

endmodule

// ===== rtl/differential_drive_speed_ramp.sv =====
// Top level of the differential drive speed ramp and mixer.
//
// Input channel: in_valid / in_stall with in_drive_mode and in_steer_correction.
// A transaction takes place on a clock edge with in_valid high and in_stall low.
// Each input transaction first updates the base speed by its mode (ramp down by
// 32, jump to slow speed, ramp up by 16 towards normal speed, or hard stop) and
// then yields exactly one result: left and right PWM duties, speed plus and
// minus the correction clamped to the speed, saturated to 10 bits.
// Result channel: out_valid / out_stall with out_left_duty and out_right_duty.
// A transaction passes the speed register, which stores the correction, and
// then the result register. Throughput is one transaction per cycle while
// out_stall is low; the speed update feeds back into the base speed register.
// When out_stall holds the result register, the speed stage still takes one
// more transaction; in_stall rises only once both stages are full.
// Configuration: cfg_wr_en, cfg_index, cfg_wdata write slow_speed (index 0) or
// normal_speed (index 1); other indexes are ignored.
// Synchronous reset (rst_n low) empties both stages, sets base speed to zero
// and the registers to 256 and 512.
module differential_drive_speed_ramp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ddsr_pkg::MODE_W-1:0]    in_drive_mode,
  input  logic signed [ddsr_pkg::CORR_W-1:0] in_steer_correction,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ddsr_pkg::SPEED_W-1:0]   out_left_duty,
  output logic [ddsr_pkg::SPEED_W-1:0]   out_right_duty,
  input  logic                           cfg_wr_en,
  input  logic [ddsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ddsr_pkg::SPEED_W-1:0]   cfg_wdata
);
  import ddsr_pkg::*;

  cfg_t      cfg;
  stage_hs_t hs;
  logic      accept;
  logic      stage_valid;
  speed_t    speed;
  corr_t     corr;

  assign in_stall = !hs.advance;
  assign accept   = in_valid && hs.advance;

  ddsr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ddsr_speed u_speed (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .accept           (accept),
    .advance          (hs.advance),
    .drive_mode       (in_drive_mode),
    .steer_correction (in_steer_correction),
    .stage_valid      (stage_valid),
    .speed            (speed),
    .corr             (corr)
  );

  ddsr_mix u_mix (
    .clk            (clk),
    .rst_n          (rst_n),
    .speed          (speed),
    .corr           (corr),
    .stage_valid    (stage_valid),
    .hs             (hs),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_left_duty  (out_left_duty),
    .out_right_duty (out_right_duty)
  );

endmodule

// ===== rtl/ddsr_checker.sv =====
// Port-level checks for the differential drive speed ramp, bound to the top level.
module ddsr_assertions (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [ddsr_pkg::MODE_W-1:0]    in_drive_mode,
  input logic signed [ddsr_pkg::CORR_W-1:0] in_steer_correction,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ddsr_pkg::SPEED_W-1:0]   out_left_duty,
  input logic [ddsr_pkg::SPEED_W-1:0]   out_right_duty,
  input logic                           cfg_wr_en,
  input logic [ddsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [ddsr_pkg::SPEED_W-1:0]   cfg_wdata
);
  import ddsr_pkg::*;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_duty)
                                && $stable(out_right_duty))
    else $error("stalled result changed");

  // unsaturated duties are speed +/- correction, so they share parity
  a_duty_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_left_duty != SPEED_MAX && out_right_duty != SPEED_MAX
      |-> out_left_duty[0] == out_right_duty[0])
    else $error("left and right duty not symmetric about speed");

  // with both stages empty the input cannot be stalled
  a_no_spurious_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(!in_valid) && $past(rst_n) |-> !in_stall)
    else $error("input stalled while pipeline empty");

endmodule

bind differential_drive_speed_ramp ddsr_assertions u_ddsr_assertions (.*);
